// ===== rtl/core/stfe_pkg.sv =====
// ----------------------------------------------------------------------------
// stfe_pkg
// Shared types and codes for the screen transition fade engine.
// ----------------------------------------------------------------------------
package stfe_pkg;

	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_CLEAR = 3'd1;
	localparam logic [2:0] KIND_FULL  = 3'd2;
	localparam logic [2:0] KIND_OUT   = 3'd3;
	localparam logic [2:0] KIND_IN    = 3'd4;
	localparam logic [2:0] KIND_FLASH = 3'd5;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_HOLD   = 3'd1;
	localparam logic [2:0] MODE_IN     = 3'd2;
	localparam logic [2:0] MODE_OUT    = 3'd3;
	localparam logic [2:0] MODE_FLASH0 = 3'd4;
	localparam logic [2:0] MODE_FLASH1 = 3'd5;
	localparam logic [2:0] MODE_FLASH2 = 3'd6;

	localparam logic [1:0] PHASE_CLEAR = 2'd0;
	localparam logic [1:0] PHASE_IN    = 2'd1;
	localparam logic [1:0] PHASE_FULL  = 2'd2;
	localparam logic [1:0] PHASE_OUT   = 2'd3;

	localparam logic [15:0] LEVEL_ZERO = 16'd0;
	localparam logic [15:0] LEVEL_MAX  = 16'd255;
	localparam logic [15:0] REARM_STEP = 16'd4;
	localparam logic [7:0]  TINT_BLACK = 8'd0;

	typedef struct packed {
		logic [2:0]  mode;
		logic [1:0]  phase;
		logic [15:0] level;
		logic [15:0] step;
		logic [7:0]  tint;
	} fade_state_t;

endpackage

// ===== rtl/core/stfe_next.sv =====
// ----------------------------------------------------------------------------
// stfe_next
// Next-state logic: applies one command or tick to the fade state.
// ----------------------------------------------------------------------------
module stfe_next (
	input  stfe_pkg::fade_state_t cur,
	input  logic [2:0]            kind,
	input  logic [15:0]           step_size,
	input  logic [7:0]            colour_value,
	input  logic [7:0]            default_colour,
	output stfe_pkg::fade_state_t nxt,
	output logic                  active
);

	logic [15:0] level_dn;
	logic [15:0] level_up;

	assign level_dn = cur.level - cur.step;
	assign level_up = cur.level + cur.step;

	always_comb begin
		nxt    = cur;
		active = 1'b0;
		unique case (kind)
			stfe_pkg::KIND_TICK: begin
				active = (cur.mode != stfe_pkg::MODE_IDLE);
				unique case (cur.mode)
					stfe_pkg::MODE_IDLE: begin
						unique case (cur.phase)
							stfe_pkg::PHASE_FULL: begin
								nxt.phase = stfe_pkg::PHASE_FULL;
								nxt.mode  = stfe_pkg::MODE_HOLD;
								nxt.tint  = default_colour;
								nxt.level = stfe_pkg::LEVEL_MAX;
							end
							stfe_pkg::PHASE_OUT: begin
								nxt.phase = stfe_pkg::PHASE_OUT;
								nxt.step  = stfe_pkg::REARM_STEP;
								nxt.mode  = stfe_pkg::MODE_OUT;
								nxt.tint  = default_colour;
							end
							stfe_pkg::PHASE_IN: begin
								nxt.phase = stfe_pkg::PHASE_CLEAR;
								nxt.level = stfe_pkg::LEVEL_ZERO;
							end
							default: begin
								nxt = cur;
							end
						endcase
					end
					stfe_pkg::MODE_HOLD: begin
						unique case (cur.phase)
							stfe_pkg::PHASE_CLEAR: begin
								nxt.phase = stfe_pkg::PHASE_CLEAR;
								nxt.mode  = stfe_pkg::MODE_IDLE;
								nxt.tint  = default_colour;
								nxt.level = stfe_pkg::LEVEL_ZERO;
							end
							stfe_pkg::PHASE_IN: begin
								nxt.phase = stfe_pkg::PHASE_IN;
								nxt.step  = stfe_pkg::REARM_STEP;
								nxt.mode  = stfe_pkg::MODE_IN;
								nxt.tint  = default_colour;
							end
							default: begin
								nxt.phase = stfe_pkg::PHASE_FULL;
								nxt.level = stfe_pkg::LEVEL_MAX;
							end
						endcase
					end
					stfe_pkg::MODE_IN: begin
						if (cur.phase == stfe_pkg::PHASE_FULL) begin
							nxt.mode = stfe_pkg::MODE_OUT;
						end else if (level_dn[15]) begin
							nxt.level = stfe_pkg::LEVEL_ZERO;
							nxt.mode  = stfe_pkg::MODE_IDLE;
							nxt.phase = stfe_pkg::PHASE_CLEAR;
						end else begin
							nxt.phase = stfe_pkg::PHASE_IN;
							nxt.level = level_dn;
						end
					end
					stfe_pkg::MODE_OUT: begin
						if (cur.phase == stfe_pkg::PHASE_CLEAR) begin
							nxt.mode = stfe_pkg::MODE_IN;
						end else if ($signed(level_up) >= $signed(stfe_pkg::LEVEL_MAX)) begin
							nxt.level = stfe_pkg::LEVEL_MAX;
							nxt.mode  = stfe_pkg::MODE_HOLD;
							nxt.phase = stfe_pkg::PHASE_FULL;
						end else begin
							nxt.phase = stfe_pkg::PHASE_OUT;
							nxt.level = level_up;
						end
					end
					stfe_pkg::MODE_FLASH0: begin
						nxt.mode = stfe_pkg::MODE_FLASH1;
					end
					stfe_pkg::MODE_FLASH1: begin
						nxt.mode = stfe_pkg::MODE_FLASH2;
					end
					stfe_pkg::MODE_FLASH2: begin
						nxt.mode = stfe_pkg::MODE_IN;
					end
					default: begin
						nxt = cur;
					end
				endcase
			end
			stfe_pkg::KIND_CLEAR: begin
				nxt.phase = stfe_pkg::PHASE_CLEAR;
				nxt.mode  = stfe_pkg::MODE_IDLE;
				nxt.tint  = colour_value;
				nxt.level = stfe_pkg::LEVEL_ZERO;
			end
			stfe_pkg::KIND_FULL: begin
				nxt.phase = stfe_pkg::PHASE_FULL;
				nxt.mode  = stfe_pkg::MODE_HOLD;
				nxt.tint  = colour_value;
				nxt.level = stfe_pkg::LEVEL_MAX;
			end
			stfe_pkg::KIND_OUT: begin
				nxt.phase = stfe_pkg::PHASE_OUT;
				nxt.step  = step_size;
				nxt.mode  = stfe_pkg::MODE_OUT;
				nxt.tint  = colour_value;
			end
			stfe_pkg::KIND_IN: begin
				nxt.phase = stfe_pkg::PHASE_IN;
				nxt.step  = step_size;
				nxt.mode  = stfe_pkg::MODE_IN;
				nxt.tint  = colour_value;
			end
			stfe_pkg::KIND_FLASH: begin
				nxt.phase = stfe_pkg::PHASE_IN;
				nxt.step  = step_size;
				nxt.mode  = stfe_pkg::MODE_FLASH0;
				nxt.tint  = stfe_pkg::TINT_BLACK;
			end
			default: begin
				nxt = cur;
			end
		endcase
	end

endmodule

// ===== rtl/core/screen_transition_fade_engine.sv =====
// Takes one request per clock cycle unless the output stalls, and returns exactly
// one result per request, from an output register loaded at acceptance. A request
// is taken whenever the output register is empty or its result is being taken in
// the same cycle, so a new request can follow every cycle. The fade state is updated
// at acceptance by an add or a subtract and a compare.
// The colour register on the cfg port is always ready; write it only while idle.
// ----------------------------------------------------------------------------
// screen_transition_fade_engine
// Fade-transition sequencer: commands load the fade, ticks advance the ramp.
// ----------------------------------------------------------------------------
module screen_transition_fade_engine (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         kind,
	input  logic signed [15:0] step_size,
	input  logic [7:0]         colour_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               was_active,
	output logic signed [15:0] level_now,
	output logic [7:0]         colour_now,
	output logic [2:0]         mode_now
);

	stfe_pkg::fade_state_t state_q;
	stfe_pkg::fade_state_t state_nxt;
	logic [7:0]            default_colour_q;
	logic                  active;
	logic                  out_valid_q;
	logic                  was_active_q;
	logic                  accept;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;

	stfe_next u_next (
		.cur            (state_q),
		.kind           (kind),
		.step_size      (step_size),
		.colour_value   (colour_value),
		.default_colour (default_colour_q),
		.nxt            (state_nxt),
		.active         (active)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_colour_q <= 8'd0;
		end else if (cfg_valid) begin
			default_colour_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				state_q     <= state_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			was_active_q <= active;
		end
	end

	assign out_valid  = out_valid_q;
	assign was_active = was_active_q;
	assign level_now  = state_q.level;
	assign colour_now = state_q.tint;
	assign mode_now   = state_q.mode;

endmodule

// ===== verif/screen_transition_fade_engine_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_transition_fade_engine_test
// Self-checking bench for the fade sequencer. Requests are predicted at
// acceptance by a local model of the fade state and the results are compared
// in order, under random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------
module screen_transition_fade_engine_test;

	localparam logic [2:0] KIND_SPARE6 = 3'd6;
	localparam logic [2:0] KIND_SPARE7 = 3'd7;
	localparam int HOLD_CYCLES = 120;
	localparam int STALL_LIMIT = 2000;
	localparam int ROUND_REQUESTS = 260;

	typedef struct packed {
		logic        was_active;
		logic [15:0] level;
		logic [7:0]  colour;
		logic [2:0]  mode;
	} fade_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [7:0]         cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic [2:0]         kind;
	logic signed [15:0] step_size;
	logic [7:0]         colour_value;
	logic               out_valid;
	logic               out_ready;
	logic               was_active;
	logic signed [15:0] level_now;
	logic [7:0]         colour_now;
	logic [2:0]         mode_now;

	// predicted fade state
	logic [2:0]  cur_mode;
	logic [1:0]  cur_phase;
	logic [15:0] cur_level;
	logic [15:0] cur_step;
	logic [7:0]  cur_tint;
	logic [7:0]  shade_default;

	fade_result_t expected_fades[$];

	int requests_sent;
	int useful_requests;
	int results_seen;
	int colour_writes;
	int mismatches;
	int idle_cycles;
	int gap_pct;
	int stall_pct;
	bit hold_request;

	screen_transition_fade_engine uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.kind         (kind),
		.step_size    (step_size),
		.colour_value (colour_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.was_active   (was_active),
		.level_now    (level_now),
		.colour_now   (colour_now),
		.mode_now     (mode_now)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void load_clear(input logic [7:0] col);
		cur_phase = stfe_pkg::PHASE_CLEAR;
		cur_mode  = stfe_pkg::MODE_IDLE;
		cur_tint  = col;
		cur_level = stfe_pkg::LEVEL_ZERO;
	endfunction

	function automatic void load_full(input logic [7:0] col);
		cur_phase = stfe_pkg::PHASE_FULL;
		cur_mode  = stfe_pkg::MODE_HOLD;
		cur_tint  = col;
		cur_level = stfe_pkg::LEVEL_MAX;
	endfunction

	function automatic void load_out(input logic [15:0] stp, input logic [7:0] col);
		cur_phase = stfe_pkg::PHASE_OUT;
		cur_step  = stp;
		cur_mode  = stfe_pkg::MODE_OUT;
		cur_tint  = col;
	endfunction

	function automatic void load_in(input logic [15:0] stp, input logic [7:0] col);
		cur_phase = stfe_pkg::PHASE_IN;
		cur_step  = stp;
		cur_mode  = stfe_pkg::MODE_IN;
		cur_tint  = col;
	endfunction

	function automatic fade_result_t advance_fade(input logic [2:0] k,
			input logic [15:0] stp, input logic [7:0] col);
		fade_result_t r;
		r.was_active = 1'b0;
		case (k)
		stfe_pkg::KIND_TICK: begin
			r.was_active = (cur_mode != stfe_pkg::MODE_IDLE);
			case (cur_mode)
			stfe_pkg::MODE_IDLE: begin
				if (cur_phase == stfe_pkg::PHASE_FULL)
					load_full(shade_default);
				else if (cur_phase == stfe_pkg::PHASE_OUT)
					load_out(stfe_pkg::REARM_STEP, shade_default);
				else if (cur_phase != stfe_pkg::PHASE_CLEAR) begin
					cur_phase = stfe_pkg::PHASE_CLEAR;
					cur_level = stfe_pkg::LEVEL_ZERO;
				end
			end
			stfe_pkg::MODE_HOLD: begin
				if (cur_phase == stfe_pkg::PHASE_CLEAR)
					load_clear(shade_default);
				else if (cur_phase == stfe_pkg::PHASE_IN)
					load_in(stfe_pkg::REARM_STEP, shade_default);
				else begin
					cur_phase = stfe_pkg::PHASE_FULL;
					cur_level = stfe_pkg::LEVEL_MAX;
				end
			end
			stfe_pkg::MODE_IN: begin
				if (cur_phase == stfe_pkg::PHASE_FULL)
					cur_mode = stfe_pkg::MODE_OUT;
				else begin
					cur_phase = stfe_pkg::PHASE_IN;
					cur_level = cur_level - cur_step;
					if (cur_level[15]) begin
						cur_level = stfe_pkg::LEVEL_ZERO;
						cur_mode  = stfe_pkg::MODE_IDLE;
						cur_phase = stfe_pkg::PHASE_CLEAR;
					end
				end
			end
			stfe_pkg::MODE_OUT: begin
				if (cur_phase == stfe_pkg::PHASE_CLEAR)
					cur_mode = stfe_pkg::MODE_IN;
				else begin
					cur_phase = stfe_pkg::PHASE_OUT;
					cur_level = cur_level + cur_step;
					if (!cur_level[15] && cur_level >= stfe_pkg::LEVEL_MAX) begin
						cur_level = stfe_pkg::LEVEL_MAX;
						cur_mode  = stfe_pkg::MODE_HOLD;
						cur_phase = stfe_pkg::PHASE_FULL;
					end
				end
			end
			stfe_pkg::MODE_FLASH0, stfe_pkg::MODE_FLASH1: cur_mode = cur_mode + 3'd1;
			stfe_pkg::MODE_FLASH2: cur_mode = stfe_pkg::MODE_IN;
			default: ;
			endcase
		end
		stfe_pkg::KIND_CLEAR: load_clear(col);
		stfe_pkg::KIND_FULL:  load_full(col);
		stfe_pkg::KIND_OUT:   load_out(stp, col);
		stfe_pkg::KIND_IN:    load_in(stp, col);
		stfe_pkg::KIND_FLASH: begin
			cur_phase = stfe_pkg::PHASE_IN;
			cur_step  = stp;
			cur_mode  = stfe_pkg::MODE_FLASH0;
			cur_tint  = stfe_pkg::TINT_BLACK;
		end
		default: ;
		endcase
		r.level  = cur_level;
		r.colour = cur_tint;
		r.mode   = cur_mode;
		return r;
	endfunction

	task automatic note_mismatch(input string what, input int exp_val, input int got_val);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected %0d, got %0d", $time, what, exp_val, got_val);
	endtask

	task automatic send_request(input logic [2:0] k, input logic [15:0] stp,
			input logic [7:0] col);
		kind         <= k;
		step_size    <= stp;
		colour_value <= col;
		if (!in_valid)
			in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		expected_fades.push_back(advance_fade(k, stp, col));
		requests_sent++;
		if (k <= stfe_pkg::KIND_FLASH)
			useful_requests++;
		if ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
	endtask

	task automatic await_idle();
		if (in_valid)
			in_valid <= 1'b0;
		while (expected_fades.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_default_colour(input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		shade_default = val;
		colour_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [15:0] random_step();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 16'($urandom_range(8, 80));
		else if (r < 80)
			return -16'($urandom_range(1, 80));
		else if (r < 85)
			return 16'd0;
		return 16'($urandom);
	endfunction

	// one command followed by a run of ticks, with a little noise mixed in
	task automatic fade_sequence(input bit calm);
		int r;
		if (!calm) begin
			case ($urandom_range(0, 2))
			0: gap_pct = 0;
			1: gap_pct = 5;
			default: gap_pct = 25;
			endcase
			case ($urandom_range(0, 2))
			0: stall_pct = 0;
			1: stall_pct = 3;
			default: stall_pct = 10;
			endcase
		end
		send_request(3'($urandom_range(stfe_pkg::KIND_CLEAR, stfe_pkg::KIND_FLASH)),
			random_step(), 8'($urandom));
		repeat ($urandom_range(1, 40)) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				send_request(3'($urandom_range(KIND_SPARE6, KIND_SPARE7)), 16'($urandom),
					8'($urandom));
			else if (r < 10)
				send_request(3'($urandom_range(stfe_pkg::KIND_CLEAR, stfe_pkg::KIND_FLASH)),
					random_step(), 8'($urandom));
			else
				send_request(stfe_pkg::KIND_TICK, 16'($urandom), 8'($urandom));
		end
	endtask

	task automatic test_reset_state();
		send_request(stfe_pkg::KIND_TICK, 16'h0000, 8'h00);
		send_request(KIND_SPARE6, 16'hffff, 8'hff);
		send_request(KIND_SPARE7, 16'h0000, 8'h00);
	endtask

	task automatic test_commands();
		send_request(stfe_pkg::KIND_CLEAR, 16'h7fff, 8'hff);
		send_request(stfe_pkg::KIND_FULL, 16'h8000, 8'h00);
		send_request(stfe_pkg::KIND_TICK, 16'hffff, 8'hff);
		send_request(stfe_pkg::KIND_IN, 16'd100, 8'haa);
		repeat (4) send_request(stfe_pkg::KIND_TICK, 16'h0000, 8'h00);
		send_request(stfe_pkg::KIND_OUT, 16'h0001, 8'h55);
		send_request(stfe_pkg::KIND_TICK, 16'h0000, 8'h00);
		send_request(stfe_pkg::KIND_FLASH, 16'h0080, 8'hff);
		repeat (4) send_request(stfe_pkg::KIND_TICK, 16'h0000, 8'h00);
		send_request(KIND_SPARE7, 16'hffff, 8'hff);
	endtask

	// a big step can carry the level past the limit and leave it unclamped
	task automatic test_ramp_overflow();
		send_request(stfe_pkg::KIND_FULL, 16'h0000, 8'h3c);
		send_request(stfe_pkg::KIND_IN, 16'd55, 8'h3c);
		send_request(stfe_pkg::KIND_TICK, 16'h0000, 8'h00);
		send_request(stfe_pkg::KIND_OUT, 16'h7fff, 8'hc3);
		send_request(stfe_pkg::KIND_TICK, 16'h0000, 8'h00);
		send_request(stfe_pkg::KIND_IN, 16'h8000, 8'h81);
		send_request(stfe_pkg::KIND_TICK, 16'h0000, 8'h00);
	endtask

	task automatic test_random_sequences();
		int target;
		for (int round = 0; round < 4; round++) begin
			await_idle();
			case (round)
			0: write_default_colour(8'hff);
			1: write_default_colour(8'h00);
			default: write_default_colour(8'($urandom));
			endcase
			target = useful_requests + ROUND_REQUESTS;
			while (useful_requests < target)
				fade_sequence(1'b0);
		end
	endtask

	task automatic test_backpressure();
		await_idle();
		gap_pct      = 0;
		stall_pct    = 0;
		hold_request = 1'b1;
		repeat (3) fade_sequence(1'b1);
		// sender waits for the last request to drain before going on
		await_idle();
	endtask

	task automatic test_calm_run();
		int target;
		write_default_colour(8'($urandom));
		gap_pct   = 0;
		stall_pct = 0;
		target = useful_requests + 120;
		while (useful_requests < target)
			fade_sequence(1'b1);
		await_idle();
	endtask

	// receiver side: random stalls plus one long hold on request
	initial begin
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_ready <= 1'b1;
				hold_request = 1'b0;
			end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		fade_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_fades.size() == 0)
				note_mismatch("unexpected result, mode", -1, mode_now);
			else begin
				want = expected_fades.pop_front();
				if (was_active !== want.was_active)
					note_mismatch("was_active", want.was_active, was_active);
				if (level_now !== want.level)
					note_mismatch("level_now", $signed(want.level), level_now);
				if (colour_now !== want.colour)
					note_mismatch("colour_now", want.colour, colour_now);
				if (mode_now !== want.mode)
					note_mismatch("mode_now", want.mode, mode_now);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout after %0d cycles without progress", idle_cycles);
			$display("screen_transition_fade_engine: mismatch");
			$finish;
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_valid       = 1'b0;
		cfg_data        = 8'h00;
		in_valid        = 1'b0;
		kind            = stfe_pkg::KIND_TICK;
		step_size       = 16'sd0;
		colour_value    = 8'h00;
		idle_cycles     = 0;
		requests_sent   = 0;
		useful_requests = 0;
		results_seen    = 0;
		colour_writes   = 0;
		mismatches      = 0;
		gap_pct         = 0;
		stall_pct       = 0;
		hold_request    = 1'b0;
		cur_mode        = stfe_pkg::MODE_IDLE;
		cur_phase       = stfe_pkg::PHASE_CLEAR;
		cur_level       = stfe_pkg::LEVEL_ZERO;
		cur_step        = 16'd0;
		cur_tint        = stfe_pkg::TINT_BLACK;
		shade_default   = stfe_pkg::TINT_BLACK;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		await_idle();
		write_default_colour(8'h9d);
		test_commands();
		test_ramp_overflow();
		test_random_sequences();
		test_backpressure();
		test_calm_run();

		repeat (4) @(posedge clk);
		if (expected_fades.size() != 0)
			note_mismatch("results still outstanding", 0, expected_fades.size());
		$display("run covered %0d requests (every command, ticks, spare kinds), %0d colour writes",
			requests_sent, colour_writes);
		$display("%0d results checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("screen_transition_fade_engine: match");
		else
			$display("screen_transition_fade_engine: mismatch");
		$finish;
	end

endmodule

// ===== screen_transition_fade_engine.f =====
rtl/core/stfe_pkg.sv
rtl/core/stfe_next.sv
rtl/core/screen_transition_fade_engine.sv
verif/screen_transition_fade_engine_test.sv
